// ----- rtl/ffba_pkg.sv -----
// ffba_pkg: types, codes and constants of the first-fit block allocator
// no dependencies; used by ffba_ctrl, ffba_dp and first_fit_block_allocator
package ffba_pkg;

  localparam int ADDR_BITS = 40;
  localparam int LEN_W     = ADDR_BITS + 1;
  localparam int HEAP_W    = 41;
  localparam int ALOG_W    = 6;
  localparam logic [ALOG_W-1:0] MIN_ALIGN_LOG2 = 6'd12;
  localparam logic [ALOG_W-1:0] MAX_ALIGN_LOG2 = 6'(ADDR_BITS);
  localparam logic [HEAP_W-1:0] HEAP_MAX       = HEAP_W'(1) << ADDR_BITS;
  localparam logic [HEAP_W-1:0] HEAP_RESET     = 41'd268435456;

  // operation codes
  localparam logic [1:0] OP_ALLOC = 2'd0;
  localparam logic [1:0] OP_FREE  = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;
  localparam logic [1:0] OP_NOP   = 2'd3;

  // status codes
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_OOM  = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;
  localparam logic [1:0] ST_BAD  = 2'd3;

  typedef struct packed {
    logic [1:0]           operation;
    logic [39:0]          request_size;
    logic [ALOG_W-1:0]    alignment_log2;
    logic [39:0]          block_offset;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [39:0] alloc_offset;
  } out_item_t;

  // one table entry
  typedef struct packed {
    logic                 free;
    logic [LEN_W-1:0]     len;
    logic [ADDR_BITS-1:0] start;
  } ent_t;

  typedef enum logic [2:0] {RA_I, RA_I_P1, RA_I_M1, RA_K_M1, RA_K_P1} rd_sel_t;
  typedef enum logic [1:0] {I_HOLD, I_ZERO, I_INC} i_op_t;
  typedef enum logic [2:0] {K_HOLD, K_CNT, K_I_P1, K_I, K_DEC, K_INC} k_op_t;
  typedef enum logic [1:0] {C_HOLD, C_LOAD, C_ADD, C_PREV} cur_op_t;
  typedef enum logic [2:0] {
    W_NONE, W_INIT, W_K_RD, W_I_USED, W_IP1_REM, W_I_FREE, W_IM1_FREE
  } wr_op_t;
  typedef enum logic [1:0] {N_HOLD, N_ONE, N_INC, N_DEC} cnt_op_t;
  typedef enum logic [2:0] {R_NONE, R_OK, R_OK_OFF, R_OOM, R_FULL, R_BAD} res_t;

  // controller to datapath
  typedef struct packed {
    logic    load;
    logic    size_calc;
    logic    rd_en;
    rd_sel_t rd_sel;
    i_op_t   i_op;
    k_op_t   k_op;
    cur_op_t cur_op;
    wr_op_t  wr_op;
    cnt_op_t cnt_op;
    res_t    res;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [1:0] op;
    logic       big_align;
    logic       hit_alloc;
    logic       exact;
    logic       full;
    logic       hit_free;
    logic       rd_free;
    logic       i_last;
    logic       i_zero;
    logic       k_gt_ip1;
    logic       k_more;
  } sts_t;

endpackage

// ----- rtl/first_fit_block_allocator.sv -----
// first_fit_block_allocator: top level of the first-fit heap block allocator
// depends on ffba_pkg, ffba_ctrl and ffba_dp
//
// Give one command per start pulse while busy is low: allocate, free or clear.
// Each command returns exactly one result beat on out_valid/out_item, one
// cycle wide, which the receiver must take as it comes. A command runs through
// the block table one entry at a time: an allocate scans the entries and moves
// those behind a split, a free scans the entries and moves those closed up by
// the merges; clear keeps busy high for one cycle.
// After reset the table entry 0 is written before busy drops.
// heap_size is written on the cfg channel while busy is low and takes effect
// at the next clear.
module first_fit_block_allocator #(
  parameter int MAX_BLOCKS = 64
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  ffba_pkg::in_item_t   in_item,
  output logic                 out_valid,
  output ffba_pkg::out_item_t  out_item,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [40:0]          cfg_data
);
  import ffba_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // configuration beats only while idle
  assign cfg_ready = !busy;

  ffba_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  ffba_dp #(
    .MAX_BLOCKS (MAX_BLOCKS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule

// ----- rtl/ffba_dp.sv -----
// ffba_dp: block table memory, index counters, size rounding and result register
// depends on ffba_pkg; driven by ffba_ctrl through cmd_t
module ffba_dp #(
  parameter int MAX_BLOCKS = 64
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  ffba_pkg::in_item_t      in_item,
  input  logic                    cfg_we,
  input  logic [40:0]             cfg_data,
  input  ffba_pkg::cmd_t          cmd,
  output ffba_pkg::sts_t          sts,
  output logic                    out_valid,
  output ffba_pkg::out_item_t     out_item
);
  import ffba_pkg::*;

  localparam int IW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int CW = $clog2(MAX_BLOCKS + 1);

  ent_t              mem [MAX_BLOCKS];
  ent_t              rdata_r;
  ent_t              cur_r;
  in_item_t          item_r;
  logic [LEN_W-1:0]  size_r;
  logic              big_r;
  logic [IW-1:0]     i_r;
  logic [IW-1:0]     k_r;
  logic [CW-1:0]     cnt_r;
  logic [HEAP_W-1:0] heap_r;
  logic              out_valid_r;
  out_item_t         out_r;

  logic [IW-1:0]     raddr;
  logic [IW-1:0]     waddr;
  logic              we;
  ent_t              wdata;
  logic [ALOG_W-1:0] alog_eff;
  logic [LEN_W-1:0]  amask;
  logic [LEN_W-1:0]  req1;
  logic [HEAP_W-1:0] heap_sat;

  // size rounding to the alignment unit
  always_comb begin
    alog_eff = (item_r.alignment_log2 < MIN_ALIGN_LOG2) ? MIN_ALIGN_LOG2
                                                        : item_r.alignment_log2;
    amask    = (LEN_W'(1) << alog_eff) - LEN_W'(1);
    req1     = (item_r.request_size == '0) ? LEN_W'(1) : LEN_W'(item_r.request_size);
    heap_sat = (heap_r > HEAP_MAX) ? HEAP_MAX : heap_r;
  end

  // read address
  always_comb begin
    unique case (cmd.rd_sel)
      RA_I:    raddr = i_r;
      RA_I_P1: raddr = i_r + IW'(1);
      RA_I_M1: raddr = i_r - IW'(1);
      RA_K_M1: raddr = k_r - IW'(1);
      RA_K_P1: raddr = k_r + IW'(1);
      default: raddr = i_r;
    endcase
  end

  // write port
  always_comb begin
    we    = 1'b1;
    waddr = i_r;
    wdata = cur_r;
    unique case (cmd.wr_op)
      W_NONE: we = 1'b0;
      W_INIT: begin
        waddr = '0;
        wdata = '{free: 1'b1, len: LEN_W'(heap_sat), start: '0};
      end
      W_K_RD: begin
        waddr = k_r;
        wdata = rdata_r;
      end
      W_I_USED: wdata = '{free: 1'b0, len: size_r, start: cur_r.start};
      W_IP1_REM: begin
        waddr = i_r + IW'(1);
        wdata = '{free: 1'b1, len: cur_r.len - size_r,
                  start: ADDR_BITS'(LEN_W'(cur_r.start) + size_r)};
      end
      W_I_FREE: wdata = '{free: 1'b1, len: cur_r.len, start: cur_r.start};
      W_IM1_FREE: begin
        waddr = i_r - IW'(1);
        wdata = '{free: 1'b1, len: cur_r.len, start: cur_r.start};
      end
      default: we = 1'b0;
    endcase
  end

  // table memory, registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (cmd.rd_en) begin
      rdata_r <= mem[raddr];
    end
  end

  // item, size, indexes and working entry
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_r <= in_item;
    end
    if (cmd.size_calc) begin
      size_r <= (req1 + amask) & ~amask;
      big_r  <= alog_eff > MAX_ALIGN_LOG2;
    end
    unique case (cmd.i_op)
      I_ZERO:  i_r <= '0;
      I_INC:   i_r <= i_r + IW'(1);
      default: i_r <= i_r;
    endcase
    unique case (cmd.k_op)
      K_CNT:   k_r <= IW'(cnt_r);
      K_I_P1:  k_r <= i_r + IW'(1);
      K_I:     k_r <= i_r;
      K_DEC:   k_r <= k_r - IW'(1);
      K_INC:   k_r <= k_r + IW'(1);
      default: k_r <= k_r;
    endcase
    unique case (cmd.cur_op)
      C_LOAD:  cur_r <= rdata_r;
      C_ADD:   cur_r.len <= cur_r.len + rdata_r.len;
      C_PREV: begin
        cur_r.start <= rdata_r.start;
        cur_r.len   <= cur_r.len + rdata_r.len;
      end
      default: cur_r <= cur_r;
    endcase
    unique case (cmd.res)
      R_OK:     out_r <= '{status: ST_OK,   alloc_offset: '0};
      R_OK_OFF: out_r <= '{status: ST_OK,   alloc_offset: cur_r.start};
      R_OOM:    out_r <= '{status: ST_OOM,  alloc_offset: '0};
      R_FULL:   out_r <= '{status: ST_FULL, alloc_offset: '0};
      R_BAD:    out_r <= '{status: ST_BAD,  alloc_offset: '0};
      default:  out_r <= out_r;
    endcase
  end

  // control registers: count, heap size, result strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= CW'(1);
      heap_r      <= HEAP_RESET;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.res != R_NONE;
      if (cfg_we) begin
        heap_r <= cfg_data;
      end
      unique case (cmd.cnt_op)
        N_ONE:   cnt_r <= CW'(1);
        N_INC:   cnt_r <= cnt_r + CW'(1);
        N_DEC:   cnt_r <= cnt_r - CW'(1);
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  // status to the controller
  always_comb begin
    sts.op        = item_r.operation;
    sts.big_align = big_r;
    sts.hit_alloc = rdata_r.free && (rdata_r.len >= size_r);
    sts.exact     = rdata_r.len == size_r;
    sts.full      = cnt_r >= CW'(MAX_BLOCKS);
    sts.hit_free  = (rdata_r.start == item_r.block_offset) && !rdata_r.free;
    sts.rd_free   = rdata_r.free;
    sts.i_last    = (CW'(i_r) + CW'(1)) >= cnt_r;
    sts.i_zero    = i_r == '0;
    sts.k_gt_ip1  = CW'(k_r) > (CW'(i_r) + CW'(1));
    sts.k_more    = (CW'(k_r) + CW'(1)) < cnt_r;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  // block count stays within the table
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r != '0) && (cnt_r <= CW'(MAX_BLOCKS)))
    else $error("block count out of range");

  // block count moves by one at most, or restarts at one
  a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r != $past(cnt_r)) |-> ((cnt_r == $past(cnt_r) + CW'(1)) ||
                                 (cnt_r == $past(cnt_r) - CW'(1)) ||
                                 (cnt_r == CW'(1))))
    else $error("block count jumped");

  // a failed result carries no offset
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_r.status != ST_OK)) |-> (out_r.alloc_offset == '0))
    else $error("offset on failed result");

endmodule

// ----- rtl/ffba_ctrl.sv -----
// ffba_ctrl: sequencer for scan, shift-insert and shift-remove passes
// depends on ffba_pkg; drives ffba_dp through cmd_t, reads sts_t
module ffba_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  output logic            busy,
  input  ffba_pkg::sts_t  sts,
  output ffba_pkg::cmd_t  cmd
);
  import ffba_pkg::*;

  typedef enum logic [4:0] {
    S_INIT, S_IDLE, S_DEC, S_A_CHK, S_A_RD, S_A_EV, S_A_EXACT, S_SU_CHK, S_SU_WR,
    S_SPLIT, S_SPLIT2, S_F_RD, S_F_EV, S_F_NX, S_F_WR, S_F_WRM, S_RM_CHK, S_RM_WR,
    S_F_PCHK, S_F_PV, S_F_PWR
  } state_t;

  state_t state_r, state_nxt;
  logic   ph_r, ph_nxt;

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    ph_nxt    = ph_r;
    cmd       = '{load: 1'b0, size_calc: 1'b0, rd_en: 1'b0, rd_sel: RA_I,
                  i_op: I_HOLD, k_op: K_HOLD, cur_op: C_HOLD, wr_op: W_NONE,
                  cnt_op: N_HOLD, res: R_NONE};
    unique case (state_r)
      S_INIT: begin
        cmd.wr_op  = W_INIT;
        cmd.cnt_op = N_ONE;
        state_nxt  = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_DEC;
        end
      end
      S_DEC: begin
        cmd.i_op = I_ZERO;
        priority if (sts.op == OP_ALLOC) begin
          cmd.size_calc = 1'b1;
          state_nxt     = S_A_CHK;
        end else if (sts.op == OP_FREE) begin
          state_nxt = S_F_RD;
        end else if (sts.op == OP_CLEAR) begin
          cmd.wr_op  = W_INIT;
          cmd.cnt_op = N_ONE;
          cmd.res    = R_OK;
          state_nxt  = S_IDLE;
        end else begin
          cmd.res   = R_OK;
          state_nxt = S_IDLE;
        end
      end
      // allocate: first-fit scan
      S_A_CHK: begin
        if (sts.big_align) begin
          cmd.res   = R_OOM;
          state_nxt = S_IDLE;
        end else begin
          cmd.rd_en = 1'b1;
          state_nxt = S_A_EV;
        end
      end
      S_A_RD: begin
        cmd.rd_en = 1'b1;
        state_nxt = S_A_EV;
      end
      S_A_EV: begin
        priority if (sts.hit_alloc) begin
          cmd.cur_op = C_LOAD;
          priority if (sts.exact) begin
            state_nxt = S_A_EXACT;
          end else if (sts.full) begin
            cmd.res   = R_FULL;
            state_nxt = S_IDLE;
          end else begin
            cmd.k_op  = K_CNT;
            state_nxt = S_SU_CHK;
          end
        end else if (sts.i_last) begin
          cmd.res   = R_OOM;
          state_nxt = S_IDLE;
        end else begin
          cmd.i_op  = I_INC;
          state_nxt = S_A_RD;
        end
      end
      S_A_EXACT: begin
        cmd.wr_op = W_I_USED;
        cmd.res   = R_OK_OFF;
        state_nxt = S_IDLE;
      end
      // open a gap behind the split block
      S_SU_CHK: begin
        if (sts.k_gt_ip1) begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RA_K_M1;
          state_nxt  = S_SU_WR;
        end else begin
          state_nxt = S_SPLIT;
        end
      end
      S_SU_WR: begin
        cmd.wr_op = W_K_RD;
        cmd.k_op  = K_DEC;
        state_nxt = S_SU_CHK;
      end
      S_SPLIT: begin
        cmd.wr_op = W_IP1_REM;
        state_nxt = S_SPLIT2;
      end
      S_SPLIT2: begin
        cmd.wr_op  = W_I_USED;
        cmd.cnt_op = N_INC;
        cmd.res    = R_OK_OFF;
        state_nxt  = S_IDLE;
      end
      // free: find the used block by its start
      S_F_RD: begin
        cmd.rd_en = 1'b1;
        state_nxt = S_F_EV;
      end
      S_F_EV: begin
        priority if (sts.hit_free) begin
          cmd.cur_op = C_LOAD;
          if (!sts.i_last) begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = RA_I_P1;
            state_nxt  = S_F_NX;
          end else begin
            state_nxt = S_F_WR;
          end
        end else if (sts.i_last) begin
          cmd.res   = R_BAD;
          state_nxt = S_IDLE;
        end else begin
          cmd.i_op  = I_INC;
          state_nxt = S_F_RD;
        end
      end
      S_F_NX: begin
        if (sts.rd_free) begin
          cmd.cur_op = C_ADD;
          state_nxt  = S_F_WRM;
        end else begin
          state_nxt = S_F_WR;
        end
      end
      S_F_WR: begin
        cmd.wr_op = W_I_FREE;
        state_nxt = S_F_PCHK;
      end
      S_F_WRM: begin
        cmd.wr_op = W_I_FREE;
        cmd.k_op  = K_I_P1;
        ph_nxt    = 1'b0;
        state_nxt = S_RM_CHK;
      end
      // close the gap of a removed entry
      S_RM_CHK: begin
        if (sts.k_more) begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RA_K_P1;
          state_nxt  = S_RM_WR;
        end else begin
          cmd.cnt_op = N_DEC;
          if (ph_r) begin
            cmd.res   = R_OK;
            state_nxt = S_IDLE;
          end else begin
            state_nxt = S_F_PCHK;
          end
        end
      end
      S_RM_WR: begin
        cmd.wr_op = W_K_RD;
        cmd.k_op  = K_INC;
        state_nxt = S_RM_CHK;
      end
      // merge with the free block in front
      S_F_PCHK: begin
        if (sts.i_zero) begin
          cmd.res   = R_OK;
          state_nxt = S_IDLE;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RA_I_M1;
          state_nxt  = S_F_PV;
        end
      end
      S_F_PV: begin
        if (sts.rd_free) begin
          cmd.cur_op = C_PREV;
          state_nxt  = S_F_PWR;
        end else begin
          cmd.res   = R_OK;
          state_nxt = S_IDLE;
        end
      end
      S_F_PWR: begin
        cmd.wr_op = W_IM1_FREE;
        cmd.k_op  = K_I;
        ph_nxt    = 1'b1;
        state_nxt = S_RM_CHK;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
      ph_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ph_r    <= ph_nxt;
    end
  end

  assign busy = state_r != S_IDLE;

  // a result is only issued on the way back to idle
  a_res_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.res != R_NONE) |=> (state_r == S_IDLE))
    else $error("result issued without returning to idle");

  // no item is taken while busy
  a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |-> (state_r == S_IDLE))
    else $error("item loaded while busy");

  // table writes never happen in idle
  a_wr_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> (cmd.wr_op == W_NONE))
    else $error("table write in idle");

endmodule
